FILE: rtl/core/hcs_pkg.sv
// Shared types, codes and mod-26 helpers for the 2x2 Hill cipher stream block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package hcs_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_KEY_R0C0     = 3'd0;
  localparam logic [2:0] REG_KEY_R0C1     = 3'd1;
  localparam logic [2:0] REG_KEY_R1C0     = 3'd2;
  localparam logic [2:0] REG_KEY_R1C1     = 3'd3;
  localparam logic [2:0] REG_MODE_DECRYPT = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NONLETTER  = 2'd1;
  localparam logic [1:0] ST_NO_INVERSE = 2'd2;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;
  localparam logic [4:0] PAD_LETTER   = 5'd23;  // 'X'

  localparam logic [10:0] MODULUS    = 11'd26;
  localparam logic [10:0] DET_BIAS   = 11'd676;  // 26*26, keeps the determinant positive
  localparam logic [19:0] MOD_RECIP  = 20'd315;  // floor(2^13 / 26)
  localparam int          RECIP_SHIFT = 13;

  // Work done for the pair part of one request
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PAIR = 2'd1,
    OP_ERR  = 2'd2
  } op_t;

  // x mod 26 for x < 2048: reciprocal estimate is low by at most one
  function automatic logic [4:0] mod26(input logic [10:0] x);
    logic [19:0] prod;
    logic [10:0] q;
    logic [10:0] r;
    prod = 20'(x) * MOD_RECIP;
    q    = 11'(prod >> RECIP_SHIFT);
    r    = x - 11'(q * MODULUS);
    if (r >= MODULUS) begin
      r = r - MODULUS;
    end
    return r[4:0];
  endfunction

  // Multiplicative inverse mod 26; 0 when none exists
  function automatic logic [4:0] inv26(input logic [4:0] d);
    logic [4:0] r;
    unique case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // (26 - x) mod 26 for x < 26
  function automatic logic [4:0] neg26(input logic [4:0] x);
    logic [4:0] r;
    if (x == 5'd0) begin
      r = 5'd0;
    end else begin
      r = 5'(MODULUS[5:0] - {1'b0, x});
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hcs_chan_if.sv
// Valid/ready channel interfaces for the Hill cipher stream block.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface hcs_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       message_end;

  modport source (output valid, output char_in, output message_end, input ready);
  modport sink   (input valid, input char_in, input message_end, output ready);
endinterface

interface hcs_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic [1:0] status;
  logic       last_of_run;
  logic       message_done;

  modport source (output valid, output char_out, output status, output last_of_run,
                  output message_done, input ready);
  modport sink   (input valid, input char_out, input status, input last_of_run,
                  input message_done, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hill_cipher_2x2_stream_top.sv
// 2x2 Hill cipher (mod 26) on an ASCII byte stream: top level.
// Depends on hcs_pkg and the channel interfaces in hcs_chan_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Letters of either case enter on char_chan, one request per cycle while the
// block is ready, and leave as uppercase ciphertext (or plaintext in decrypt
// mode) on result_chan. Every second letter completes a pair and yields two
// letters; a lone letter at message end is padded with X. A non-letter yields
// one status-1 result, and a letter under a non-invertible decrypt key yields
// one status-2 result. The path is two register stages: the request register
// (class, pair state) and a three-slot result register that the multiply and
// mod-26 logic fills. A request's results pass through the request register,
// then enter the result register once it is free. Input flows at one request
// per cycle as long as each request gives at most one result and the result
// port is not stalled; a request that gives more results holds the output
// longer, so the sustained rate is set by the single result port. The
// decrypt matrix is rebuilt from the key registers: the inverse determinant
// is registered at the configuration write and the matrix in the cycle after,
// ready before any request taken after the write reaches the multipliers.
module hill_cipher_2x2_stream_top (
  input  wire logic       clk,
  input  wire logic       rst,
  hcs_char_if.sink        char_chan,
  hcs_result_if.source    result_chan,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [4:0] cfg_data
);
  import hcs_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration: keys are stored already reduced mod 26
  // ---------------------------------------------------------------------
  logic [4:0] key_a, key_b, key_c, key_d;
  logic       mode;
  logic [4:0] inv_det;
  logic [4:0] key_a_next, key_b_next, key_c_next, key_d_next;
  logic       mode_next;
  logic [4:0] cfg_red;
  logic [4:0] det_next;

  assign cfg_red = (cfg_data >= 5'd26) ? (cfg_data - 5'd26) : cfg_data;

  always_comb begin
    key_a_next = key_a;
    key_b_next = key_b;
    key_c_next = key_c;
    key_d_next = key_d;
    mode_next  = mode;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_R0C0:     key_a_next = cfg_red;
        REG_KEY_R0C1:     key_b_next = cfg_red;
        REG_KEY_R1C0:     key_c_next = cfg_red;
        REG_KEY_R1C1:     key_d_next = cfg_red;
        REG_MODE_DECRYPT: mode_next  = cfg_data[0];
        default:          ;  // writes past the register list are dropped
      endcase
    end
  end

  // Determinant of the key as it stands after this write
  assign det_next = mod26(11'(key_a_next) * 11'(key_d_next) + DET_BIAS
                          - 11'(key_b_next) * 11'(key_c_next));

  // Active matrix: key in encrypt mode, adjugate times inverse determinant
  logic [4:0] mat0, mat1, mat2, mat3;
  logic       key_ok;

  assign key_ok = !mode || (inv_det != 5'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_a   <= 5'd1;
      key_b   <= 5'd0;
      key_c   <= 5'd0;
      key_d   <= 5'd1;
      mode    <= 1'b0;
      inv_det <= 5'd1;
      mat0    <= 5'd1;
      mat1    <= 5'd0;
      mat2    <= 5'd0;
      mat3    <= 5'd1;
    end else begin
      key_a   <= key_a_next;
      key_b   <= key_b_next;
      key_c   <= key_c_next;
      key_d   <= key_d_next;
      mode    <= mode_next;
      inv_det <= inv26(det_next);
      mat0    <= mode ? mod26(11'(key_d) * 11'(inv_det)) : key_a;
      mat1    <= mode ? mod26(11'(neg26(key_b)) * 11'(inv_det)) : key_b;
      mat2    <= mode ? mod26(11'(neg26(key_c)) * 11'(inv_det)) : key_c;
      mat3    <= mode ? mod26(11'(key_a) * 11'(inv_det)) : key_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: classify the request and track the held letter
  // ---------------------------------------------------------------------
  logic       pair_pending;
  logic [4:0] held_letter;
  logic       pair_pending_next;
  logic [4:0] held_letter_next;

  logic [7:0] ch_up;
  logic [7:0] ch_off;
  logic       is_letter;
  logic [4:0] letter;

  logic       plan_nl;
  op_t        plan_op;
  logic [4:0] plan_p0, plan_p1;

  logic       in_take;

  assign ch_up = (char_chan.char_in >= CHAR_LOWER_A && char_chan.char_in <= CHAR_LOWER_Z)
                 ? (char_chan.char_in - CASE_OFFSET) : char_chan.char_in;
  assign is_letter = (ch_up >= CHAR_UPPER_A) && (ch_up <= CHAR_UPPER_Z);
  assign ch_off    = ch_up - CHAR_UPPER_A;
  assign letter    = ch_off[4:0];

  always_comb begin
    plan_nl           = 1'b0;
    plan_op           = OP_NONE;
    plan_p0           = held_letter;
    plan_p1           = PAD_LETTER;
    pair_pending_next = pair_pending;
    held_letter_next  = held_letter;
    if (!is_letter) begin
      // Drop the byte; flush a held letter at message end
      plan_nl = 1'b1;
      if (char_chan.message_end) begin
        if (pair_pending) begin
          plan_op = key_ok ? OP_PAIR : OP_ERR;
        end
        pair_pending_next = 1'b0;
      end
    end else if (!key_ok) begin
      plan_op           = OP_ERR;
      pair_pending_next = 1'b0;
      held_letter_next  = 5'd0;
    end else if (pair_pending) begin
      plan_op           = OP_PAIR;
      plan_p1           = letter;
      pair_pending_next = 1'b0;
    end else if (char_chan.message_end) begin
      plan_op = OP_PAIR;
      plan_p0 = letter;
    end else begin
      // First letter of a pair: hold it
      held_letter_next  = letter;
      pair_pending_next = 1'b1;
    end
  end

  logic       a_valid;
  logic       a_nl;
  op_t        a_op;
  logic [4:0] a_p0, a_p1;
  logic       a_end;

  // ---------------------------------------------------------------------
  // Stage B: multiply mod 26 and fill the result slots
  // ---------------------------------------------------------------------
  logic [4:0] c0, c1;
  logic [7:0] let0, let1;
  logic [1:0] grp_n;
  logic [7:0] grp_char [3];
  logic [1:0] grp_st   [3];

  assign c0   = mod26(11'(mat0) * 11'(a_p0) + 11'(mat1) * 11'(a_p1));
  assign c1   = mod26(11'(mat2) * 11'(a_p0) + 11'(mat3) * 11'(a_p1));
  assign let0 = CHAR_UPPER_A + {3'b000, c0};
  assign let1 = CHAR_UPPER_A + {3'b000, c1};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      grp_char[i] = 8'd0;
      grp_st[i]   = ST_OK;
    end
    grp_n = 2'd0;
    if (a_nl) begin
      grp_st[0] = ST_NONLETTER;
      unique case (a_op)
        OP_PAIR: begin
          grp_char[1] = let0;
          grp_char[2] = let1;
          grp_n       = 2'd3;
        end
        OP_ERR: begin
          grp_st[1] = ST_NO_INVERSE;
          grp_n     = 2'd2;
        end
        default: grp_n = 2'd1;
      endcase
    end else begin
      unique case (a_op)
        OP_PAIR: begin
          grp_char[0] = let0;
          grp_char[1] = let1;
          grp_n       = 2'd2;
        end
        OP_ERR: begin
          grp_st[0] = ST_NO_INVERSE;
          grp_n     = 2'd1;
        end
        default: grp_n = 2'd0;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Result register: up to three results, drained from slot 0
  // ---------------------------------------------------------------------
  logic [7:0] res_char [3];
  logic [1:0] res_st   [3];
  logic [1:0] res_left;
  logic       res_end;

  logic       res_pop;
  logic       can_load;
  logic       a_consume;
  logic       grp_load;

  assign res_pop   = (res_left != 2'd0) && result_chan.ready;
  assign can_load  = (res_left == 2'd0) || ((res_left == 2'd1) && result_chan.ready);
  assign a_consume = a_valid && ((grp_n == 2'd0) || can_load);
  assign grp_load  = a_consume && (grp_n != 2'd0);

  // Take a new request whenever stage A is empty or moves on this cycle
  assign char_chan.ready = !a_valid || a_consume;
  assign in_take         = char_chan.valid && char_chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      a_op         <= OP_NONE;
      pair_pending <= 1'b0;
      held_letter  <= 5'd0;
      res_left     <= 2'd0;
    end else begin
      if (in_take) begin
        a_valid      <= 1'b1;
        a_op         <= plan_op;
        pair_pending <= pair_pending_next;
        held_letter  <= held_letter_next;
      end else if (a_consume) begin
        a_valid <= 1'b0;
      end
      if (grp_load) begin
        res_left <= grp_n;
      end else if (res_pop) begin
        res_left <= res_left - 2'd1;
      end
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      a_nl  <= plan_nl;
      a_p0  <= plan_p0;
      a_p1  <= plan_p1;
      a_end <= char_chan.message_end;
    end
    if (grp_load) begin
      res_char <= grp_char;
      res_st   <= grp_st;
      res_end  <= a_end;
    end else if (res_pop) begin
      // Advance the remaining results toward slot 0
      res_char[0] <= res_char[1];
      res_char[1] <= res_char[2];
      res_st[0]   <= res_st[1];
      res_st[1]   <= res_st[2];
    end
  end

  assign result_chan.valid        = (res_left != 2'd0);
  assign result_chan.char_out     = res_char[0];
  assign result_chan.status       = res_st[0];
  assign result_chan.last_of_run  = (res_left == 2'd1);
  assign result_chan.message_done = (res_left == 2'd1) && res_end;

endmodule

`default_nettype wire

FILE: rtl/core/hcs_checker.sv
// Port-level checks for hill_cipher_2x2_stream_top, attached by bind below.
// Depends on hcs_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module hcs_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] char_out,
  input wire logic [1:0] status,
  input wire logic       last_of_run,
  input wire logic       message_done
);
  import hcs_pkg::*;

  // End of message always closes the request's run
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_done |-> last_of_run)
    else $error("message_done without last_of_run");

  // Letter results carry an uppercase letter
  a_ok_letter: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> char_out >= CHAR_UPPER_A && char_out <= CHAR_UPPER_Z)
    else $error("ok result is not an uppercase letter");

  // Status results carry a known code and a zero character
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      char_out == 8'd0 && (status == ST_NONLETTER || status == ST_NO_INVERSE))
    else $error("bad status result");

  // A key error is the final result of its request
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NO_INVERSE |-> last_of_run)
    else $error("key error not last of run");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(status))
    else $error("stalled result changed");

endmodule

bind hill_cipher_2x2_stream_top hcs_checker u_hcs_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result_chan.valid),
  .out_ready    (result_chan.ready),
  .char_out     (result_chan.char_out),
  .status       (result_chan.status),
  .last_of_run  (result_chan.last_of_run),
  .message_done (result_chan.message_done)
);

`default_nettype wire
